>>> design/hrss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrss_pkg
// Shared types and constants for the heart rate scan stress scorer.
// ----------------------------------------------------------------------------
package hrss_pkg;

  localparam int unsigned MAX_SCAN_SAMPLES_DEF = 64;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_COOLDOWN  = 2'd1;
  localparam logic [1:0] REG_SAMPLES   = 2'd2;
  localparam logic [1:0] REG_SLOPE     = 2'd3;

  localparam logic [7:0]  THRESHOLD_RST = 8'd40;
  localparam logic [15:0] COOLDOWN_RST  = 16'd300;
  localparam logic [6:0]  SAMPLES_RST   = 7'd60;
  localparam logic [6:0]  SLOPE_RST     = 7'd8;

  localparam logic [6:0] SCORE_TOP   = 7'd100;
  localparam logic [6:0] SCORE_FLOOR = 7'd10;

  localparam logic [7:0] RATE_LOW_RST  = 8'd255;
  localparam logic [7:0] RATE_HIGH_RST = 8'd0;

  localparam logic CMD_TICK = 1'b1;

  localparam int unsigned QDEPTH = 2;

  typedef enum logic [0:0] {
    OP_EVENT,
    OP_TICK
  } hrss_op_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  smoothed_bpm;
    logic [7:0]  raw_bpm;
    logic [31:0] now_seconds;
  } hrss_in_t;

  typedef struct packed {
    logic [6:0] stress_score;
    logic [7:0] average_bpm;
  } hrss_out_t;

  typedef struct packed {
    hrss_op_e    op;
    logic [7:0]  raw_bpm;
    logic [31:0] now_seconds;
  } hrss_entry_t;

  typedef struct packed {
    logic [7:0]  trigger_threshold;
    logic [15:0] cooldown_seconds;
    logic [6:0]  samples_per_scan;
    logic [6:0]  score_slope;
  } hrss_cfg_t;

endpackage
`default_nettype wire

>>> design/hrss_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrss_front
// Input stage: registers each beat, drops events at or below the trigger
// threshold and hands ticks and hot events on as queue entries.
// ----------------------------------------------------------------------------
module hrss_front
  import hrss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire hrss_cfg_t   cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire hrss_in_t    in_data_i,
  output logic             ent_valid_o,
  input  wire logic        ent_ready_i,
  output hrss_entry_t      ent_o
);

  logic        valid_q, valid_d;
  hrss_entry_t ent_q, ent_d;
  logic        keep;
  logic        accept;

  assign in_ready_o = !valid_q || ent_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign keep       = (in_data_i.command == CMD_TICK) ||
                      (in_data_i.smoothed_bpm > cfg_i.trigger_threshold);

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (ent_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d         = keep;
      ent_d.op        = (in_data_i.command == CMD_TICK) ? OP_TICK : OP_EVENT;
      ent_d.raw_bpm   = in_data_i.raw_bpm;
      ent_d.now_seconds = in_data_i.now_seconds;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_valid_o = valid_q;
  assign ent_o       = ent_q;

endmodule
`default_nettype wire

>>> design/hrss_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrss_queue
// Two-entry queue between the input stage and the scan engine.
// ----------------------------------------------------------------------------
module hrss_queue
  import hrss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_valid_i,
  output logic             wr_ready_o,
  input  wire hrss_entry_t wr_data_i,
  output logic             rd_valid_o,
  input  wire logic        rd_ready_i,
  output hrss_entry_t      rd_data_o
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  hrss_entry_t             slot_q [QDEPTH];
  logic [PTR_W-1:0]        wptr_q, wptr_d;
  logic [PTR_W-1:0]        rptr_q, rptr_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    push, pop;

  assign wr_ready_o = (cnt_q != CNT_W'(QDEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

>>> design/hrss_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrss_back
// Scan engine: cooldown check, sample statistics, score and a bit-serial
// divider for the average, with an output register toward the result channel.
// ----------------------------------------------------------------------------
module hrss_back
  import hrss_pkg::*;
#(
  parameter int unsigned MAX_SCAN_SAMPLES = MAX_SCAN_SAMPLES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire hrss_cfg_t   cfg_i,
  input  wire logic        ent_valid_i,
  output logic             ent_ready_o,
  input  wire hrss_entry_t ent_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output hrss_out_t        out_data_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_SCAN_SAMPLES + 1);
  localparam int unsigned SUM_W  = $clog2(MAX_SCAN_SAMPLES * 255 + 1);
  localparam int unsigned TGT_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic              scanning_q, scanning_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [7:0]        low_q, low_d;
  logic [7:0]        high_q, high_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [31:0]       last_q, last_d;

  logic [CNT_W-1:0]  divisor_q, divisor_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [6:0]        score_q, score_d;

  logic              out_valid_q, out_valid_d;
  hrss_out_t         out_q, out_d;

  logic              take, is_event, start, active;
  logic [CNT_W-1:0]  count_b;
  logic [7:0]        low_b, high_b;
  logic [SUM_W-1:0]  sum_b;
  logic [TGT_W-1:0]  target;
  logic [TGT_W-1:0]  samples_ext;
  logic [7:0]        range;
  logic [14:0]       prod;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign ent_ready_o = (state_q == ST_IDLE);
  assign take        = ent_valid_i && ent_ready_o;
  assign is_event    = (ent_i.op == OP_EVENT);
  assign start       = is_event && !scanning_q &&
                       ((ent_i.now_seconds - last_q) >= 32'(cfg_i.cooldown_seconds));
  assign active      = start || (!is_event && scanning_q);

  assign count_b = start ? '0 : count_q;
  assign low_b   = start ? RATE_LOW_RST : low_q;
  assign high_b  = start ? RATE_HIGH_RST : high_q;
  assign sum_b   = start ? '0 : sum_q;

  assign samples_ext = TGT_W'(cfg_i.samples_per_scan);
  assign target      = (samples_ext > TGT_W'(MAX_SCAN_SAMPLES)) ?
                       TGT_W'(MAX_SCAN_SAMPLES) : samples_ext;

  assign range = (high_b == 8'd0) ? 8'd0 : (high_b - low_b);
  assign prod  = 15'(range) * 15'(cfg_i.score_slope);

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = (trial >= (CNT_W + 1)'(divisor_q));

  always_comb begin
    state_d     = state_q;
    scanning_d  = scanning_q;
    count_d     = count_q;
    low_d       = low_q;
    high_d      = high_q;
    sum_d       = sum_q;
    last_d      = last_q;
    divisor_d   = divisor_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    score_d     = score_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (take && active) begin
          count_d = count_b;
          low_d   = low_b;
          high_d  = high_b;
          sum_d   = sum_b;
          if (start) begin
            last_d     = ent_i.now_seconds;
            scanning_d = 1'b1;
          end
          if (TGT_W'(count_b) < target) begin
            if (ent_i.raw_bpm != 8'd0) begin
              if (ent_i.raw_bpm < low_b) begin
                low_d = ent_i.raw_bpm;
              end
              if (ent_i.raw_bpm > high_b) begin
                high_d = ent_i.raw_bpm;
              end
              sum_d   = sum_b + SUM_W'(ent_i.raw_bpm);
              count_d = count_b + CNT_W'(1);
            end
          end else begin
            scanning_d = 1'b0;
            score_d    = (prod >= 15'(SCORE_TOP - SCORE_FLOOR)) ?
                         SCORE_FLOOR : 7'(15'(SCORE_TOP) - prod);
            divisor_d  = count_b;
            rem_d      = '0;
            quo_d      = sum_b;
            step_d     = '0;
            state_d    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d  = ge ? CNT_W'(trial - (CNT_W + 1)'(divisor_q)) : CNT_W'(trial);
        quo_d  = {quo_q[SUM_W-2:0], ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.stress_score   = score_q;
          out_d.average_bpm    = (divisor_q == '0) ? 8'd0 : quo_q[7:0];
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scanning_q  <= 1'b0;
      count_q     <= '0;
      low_q       <= RATE_LOW_RST;
      high_q      <= RATE_HIGH_RST;
      sum_q       <= '0;
      last_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scanning_q  <= scanning_d;
      count_q     <= count_d;
      low_q       <= low_d;
      high_q      <= high_d;
      sum_q       <= sum_d;
      last_q      <= last_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    score_q   <= score_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> design/heart_rate_scan_stress_scorer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heart_rate_scan_stress_scorer
// Heart rate scan controller producing a stress score and average rate.
// ----------------------------------------------------------------------------
// An input stage takes one beat per cycle while the two-entry queue behind it
// has room; events at or below the trigger threshold are dropped there. The
// scan engine retires an event or a non-final tick straight from its idle
// state. The beat that completes a scan runs a one-bit-per-cycle divider for
// the average, and later beats wait in the queue until the result has gone
// into an output register, so the engine keeps working while that result
// waits to be taken.
// ----------------------------------------------------------------------------
module heart_rate_scan_stress_scorer
  import hrss_pkg::*;
#(
  parameter int unsigned MAX_SCAN_SAMPLES = MAX_SCAN_SAMPLES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hrss_in_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hrss_out_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  hrss_cfg_t   cfg_q, cfg_d;
  logic [1:0]  reg_idx;
  logic        wr_en;

  logic        fr_valid, fr_ready;
  hrss_entry_t fr_ent;
  logic        q_valid, q_ready;
  hrss_entry_t q_ent;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_THRESHOLD: cfg_d.trigger_threshold = pwdata[7:0];
        REG_COOLDOWN:  cfg_d.cooldown_seconds  = pwdata[15:0];
        REG_SAMPLES:   cfg_d.samples_per_scan  = pwdata[6:0];
        REG_SLOPE:     cfg_d.score_slope       = pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = APB_DW'(cfg_q.trigger_threshold);
      REG_COOLDOWN:  prdata = APB_DW'(cfg_q.cooldown_seconds);
      REG_SAMPLES:   prdata = APB_DW'(cfg_q.samples_per_scan);
      REG_SLOPE:     prdata = APB_DW'(cfg_q.score_slope);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_threshold <= THRESHOLD_RST;
      cfg_q.cooldown_seconds  <= COOLDOWN_RST;
      cfg_q.samples_per_scan  <= SAMPLES_RST;
      cfg_q.score_slope       <= SLOPE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hrss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .ent_valid_o (fr_valid),
    .ent_ready_i (fr_ready),
    .ent_o       (fr_ent)
  );

  hrss_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_ent),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_ent)
  );

  hrss_back #(
    .MAX_SCAN_SAMPLES (MAX_SCAN_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ent_valid_i (q_valid),
    .ent_ready_o (q_ready),
    .ent_i       (q_ent),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
